>>> sv/gct_pkg.sv
package gct_pkg;

    // Default store depth
    localparam int MAX_RECORDS_DEF = 1024;

    // Field widths
    localparam int FRAME_W   = 24;
    localparam int ID_W      = 16;
    localparam int BOX_W     = 16;
    localparam int CEN_W     = 18;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 16;
    localparam int PIX_W     = 12;
    localparam int WIN_W     = 8;
    localparam int LA_W      = 10;
    localparam int FACE_W    = 2;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 4;
    // Window end arithmetic: frame + window + lookahead stays below 2^26
    localparam int WF_W      = 26;

    // Serial remainder unit: one dividend bit per cycle
    localparam int REM_STEPS = FRAME_W;
    localparam int STEP_W    = $clog2(REM_STEPS);

    typedef enum logic
    {
        OP_RECORD = 1'b0,
        OP_COUNT  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_RESET_SECONDS    = 4'd0,
        REG_GATE_LEFT        = 4'd1,
        REG_GATE_TOP         = 4'd2,
        REG_GATE_RIGHT       = 4'd3,
        REG_GATE_BOTTOM      = 4'd4,
        REG_GATE_FACING      = 4'd5,
        REG_WINDOW_FRAMES    = 4'd6,
        REG_LOOKAHEAD_FRAMES = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        FACE_0   = 2'd0,
        FACE_90  = 2'd1,
        FACE_180 = 2'd2,
        FACE_270 = 2'd3
    } facing_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_REC,
        S_MM,
        S_LD_I,
        S_LD_W,
        S_DIV,
        S_WCHK,
        S_SCAN,
        S_TALLY,
        S_WNEXT,
        S_FIN
    } state_t;

    typedef struct packed
    {
        op_t                op;
        logic [FRAME_W-1:0] frame_number;
        logic [ID_W-1:0]    track_id;
        logic [BOX_W-1:0]   box_x;
        logic [BOX_W-1:0]   box_y;
        logic [BOX_W-1:0]   box_width;
        logic [BOX_W-1:0]   box_height;
        logic [TIME_W-1:0]  now_seconds;
    } item_t;

    typedef struct packed
    {
        logic [FRAME_W-1:0] frame_used;
        logic               totals_cleared;
        logic               store_full;
        logic [CNT_W-1:0]   count_in;
        logic [CNT_W-1:0]   count_out;
    } result_t;

    // One stored detection
    typedef struct packed
    {
        logic [FRAME_W-1:0] frame;
        logic [ID_W-1:0]    id;
        logic [CEN_W-1:0]   cx2;
        logic [CEN_W-1:0]   cy2;
    } rec_t;

endpackage

>>> sv/gate_crossing_track_counter_top.sv
// Gate crossing track counter. A record word (op 0) stores one detection, unless
// the store is full, in a record memory with one write and one registered read
// port; its result goes to the output register once that register is free. The
// store is cleared by a record word that arrives reset_seconds or more after the
// episode start. A count word (op 1) walks the memory: one pass finds the frame
// span, then for each of the n records a read, a serial remainder and, for each
// of its one or two windows, a check, a memory scan, a tally and a step (a window
// past the greatest frame costs only its check and step). With an empty store it
// goes straight to its result. One word is worked on at a time; the next word is
// taken while the previous result waits in the output register.
module gate_crossing_track_counter_top
    import gct_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    state_t state_reg, state_next;
    item_t  item_reg, item_next;

    // Configuration
    logic [TIME_W-1:0] reset_s_reg;
    logic [PIX_W-1:0]  gl_reg, gt_reg, gr_reg, gb_reg;
    logic [FACE_W-1:0] facing_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [LA_W-1:0]   la_reg;

    // Store bookkeeping
    logic [CW-1:0]     count_reg, count_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              started_reg, started_next;

    // Output register
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;

    // Count walk
    logic [FRAME_W-1:0] fmin_reg, fmin_next, fmax_reg, fmax_next;
    logic [CW-1:0]      i_reg, i_next, a_reg, a_next, di_reg, di_next;
    logic               dv_reg, dv_next;
    rec_t               cur_reg, cur_next;
    logic [WF_W-1:0]    wf_reg, wf_next, wf2_reg, wf2_next;
    logic               second_reg, second_next;
    logic               nf_reg, nf_next, sup_reg, sup_next;
    logic [CEN_W-1:0]   lx_reg, lx_next, ly_reg, ly_next;
    logic [CNT_W-1:0]   cin_reg, cin_next, cout_reg, cout_next;

    // Memory and remainder unit
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    rec_t          wr_data, rd_data;
    logic          rem_start, rem_done;
    logic [WIN_W-1:0] rem_val;

    // Shared decode
    logic [WIN_W-1:0]   weff;
    logic               slot_free, scan_done, in_win, in_la, id_match, in_gate, dir_in;
    logic [WF_W-1:0]    rd_f;
    logic [TIME_W-1:0]  now;
    logic               clear_now;
    logic [CW-1:0]      count_eff;

    gct_store #(.DEPTH(MAX_RECORDS), .AW(AW)) u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gct_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (FRAME_W'(rd_data.frame - fmin_reg)),
        .divisor   (weff),
        .done      (rem_done),
        .remainder (rem_val)
    );

    assign weff       = (win_reg == '0) ? WIN_W'(1) : win_reg;
    assign slot_free  = !res_valid_reg || result_ready;
    assign scan_done  = (a_reg == count_reg) && !dv_reg;
    assign item_ready = (state_reg == S_IDLE);

    // Record decode
    assign now       = item_reg.now_seconds;
    assign clear_now = started_reg && (now >= start_reg) && ((now - start_reg) >= reset_s_reg);
    assign count_eff = clear_now ? '0 : count_reg;

    // Scan compare against the current window
    assign rd_f     = WF_W'(rd_data.frame);
    assign id_match = (rd_data.id == cur_reg.id);
    assign in_win   = (rd_f + WF_W'(weff) >= wf_reg) && (rd_f <= wf_reg);
    assign in_la    = (rd_f > wf_reg) && (rd_f <= wf_reg + WF_W'(la_reg));

    // Gate test and direction
    assign in_gate = (lx_reg >= CEN_W'({gl_reg, 5'b0})) && (lx_reg <= CEN_W'({gr_reg, 5'b0}))
                  && (ly_reg >= CEN_W'({gt_reg, 5'b0})) && (ly_reg <= CEN_W'({gb_reg, 5'b0}));

    always_comb
    begin
        case (facing_t'(facing_reg))
            FACE_0:   dir_in = (lx_reg < cur_reg.cx2);
            FACE_90:  dir_in = (cur_reg.cy2 < ly_reg);
            FACE_180: dir_in = !(lx_reg < cur_reg.cx2);
            FACE_270: dir_in = !(cur_reg.cy2 < ly_reg);
            default:  dir_in = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.op == OP_COUNT)
                    begin
                        state_next = (count_reg == '0) ? S_FIN : S_MM;
                    end
                    else
                    begin
                        state_next = S_REC;
                    end
                end
            end
            S_REC:   state_next = slot_free ? S_IDLE : S_REC;
            S_MM:    state_next = scan_done ? S_LD_I : S_MM;
            S_LD_I:  state_next = S_LD_W;
            S_LD_W:  state_next = S_DIV;
            S_DIV:   state_next = rem_done ? S_WCHK : S_DIV;
            S_WCHK:  state_next = (wf_reg <= WF_W'(fmax_reg)) ? S_SCAN : S_WNEXT;
            S_SCAN:  state_next = scan_done ? S_TALLY : S_SCAN;
            S_TALLY: state_next = S_WNEXT;
            S_WNEXT:
            begin
                if (second_reg)
                begin
                    state_next = S_WCHK;
                end
                else
                begin
                    state_next = (i_reg + 1'b1 == count_reg) ? S_FIN : S_LD_I;
                end
            end
            S_FIN:   state_next = slot_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        item_next      = item_reg;
        count_next     = count_reg;
        start_next     = start_reg;
        started_next   = started_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        fmin_next      = fmin_reg;
        fmax_next      = fmax_reg;
        i_next         = i_reg;
        a_next         = a_reg;
        di_next        = di_reg;
        dv_next        = 1'b0;
        cur_next       = cur_reg;
        wf_next        = wf_reg;
        wf2_next       = wf2_reg;
        second_next    = second_reg;
        nf_next        = nf_reg;
        sup_next       = sup_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        cin_next       = cin_reg;
        cout_next      = cout_reg;
        wr_en          = 1'b0;
        wr_addr        = count_eff[AW-1:0];
        wr_data.frame  = clear_now ? '0 : item_reg.frame_number;
        wr_data.id     = item_reg.track_id;
        wr_data.cx2    = CEN_W'({item_reg.box_x, 1'b0}) + CEN_W'(item_reg.box_width);
        wr_data.cy2    = CEN_W'({item_reg.box_y, 1'b0}) + CEN_W'(item_reg.box_height);
        rd_addr        = a_reg[AW-1:0];
        rem_start      = 1'b0;

        // Memory scan address issue, shared by both scans
        if ((state_reg == S_MM) || (state_reg == S_SCAN))
        begin
            if (a_reg != count_reg)
            begin
                a_next  = a_reg + 1'b1;
                dv_next = 1'b1;
                di_next = a_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    cin_next  = '0;
                    cout_next = '0;
                    i_next    = '0;
                    a_next    = '0;
                end
            end
            S_REC:
            begin
                if (slot_free)
                begin
                    if (!started_reg)
                    begin
                        start_next   = now;
                        started_next = 1'b1;
                    end
                    else if (clear_now)
                    begin
                        start_next = now;
                    end
                    res_next.frame_used     = wr_data.frame;
                    res_next.totals_cleared = clear_now;
                    res_next.store_full     = (count_eff >= CW'(MAX_RECORDS));
                    res_next.count_in       = '0;
                    res_next.count_out      = '0;
                    res_valid_next          = 1'b1;
                    count_next              = count_eff;
                    if (count_eff < CW'(MAX_RECORDS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_eff + 1'b1;
                    end
                end
            end
            S_MM:
            begin
                if (dv_reg)
                begin
                    if (di_reg == '0)
                    begin
                        fmin_next = rd_data.frame;
                        fmax_next = rd_data.frame;
                    end
                    else
                    begin
                        if (rd_data.frame < fmin_reg)
                        begin
                            fmin_next = rd_data.frame;
                        end
                        if (rd_data.frame > fmax_reg)
                        begin
                            fmax_next = rd_data.frame;
                        end
                    end
                end
            end
            S_LD_I:
            begin
                rd_addr = i_reg[AW-1:0];
            end
            S_LD_W:
            begin
                cur_next  = rd_data;
                rem_start = 1'b1;
            end
            S_DIV:
            begin
                // On a boundary the record sits in two windows
                if (rem_val == '0)
                begin
                    wf_next     = WF_W'(cur_reg.frame);
                    wf2_next    = WF_W'(cur_reg.frame) + WF_W'(weff);
                    second_next = 1'b1;
                end
                else
                begin
                    wf_next     = WF_W'(cur_reg.frame) - WF_W'(rem_val) + WF_W'(weff);
                    second_next = 1'b0;
                end
            end
            S_WCHK:
            begin
                a_next   = '0;
                nf_next  = 1'b0;
                sup_next = 1'b0;
                lx_next  = cur_reg.cx2;
                ly_next  = cur_reg.cy2;
            end
            S_SCAN:
            begin
                if (dv_reg && id_match)
                begin
                    if (in_win && (di_reg < i_reg))
                    begin
                        nf_next = 1'b1;
                    end
                    if (in_la)
                    begin
                        sup_next = 1'b1;
                    end
                    if (in_win && (di_reg > i_reg))
                    begin
                        lx_next = rd_data.cx2;
                        ly_next = rd_data.cy2;
                    end
                end
            end
            S_TALLY:
            begin
                if (!nf_reg && !sup_reg && in_gate)
                begin
                    if (dir_in)
                    begin
                        if (cin_reg != '1)
                        begin
                            cin_next = cin_reg + 1'b1;
                        end
                    end
                    else if (cout_reg != '1)
                    begin
                        cout_next = cout_reg + 1'b1;
                    end
                end
            end
            S_WNEXT:
            begin
                if (second_reg)
                begin
                    wf_next     = wf2_reg;
                    second_next = 1'b0;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    res_next.frame_used     = '0;
                    res_next.totals_cleared = 1'b0;
                    res_next.store_full     = 1'b0;
                    res_next.count_in       = cin_reg;
                    res_next.count_out      = cout_reg;
                    res_valid_next          = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            start_reg     <= '0;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            dv_reg        <= 1'b0;
            a_reg         <= '0;
            i_reg         <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            started_reg   <= started_next;
            res_valid_reg <= res_valid_next;
            dv_reg        <= dv_next;
            a_reg         <= a_next;
            i_reg         <= i_next;
            second_reg    <= second_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        fmin_reg <= fmin_next;
        fmax_reg <= fmax_next;
        di_reg   <= di_next;
        cur_reg  <= cur_next;
        wf_reg   <= wf_next;
        wf2_reg  <= wf2_next;
        nf_reg   <= nf_next;
        sup_reg  <= sup_next;
        lx_reg   <= lx_next;
        ly_reg   <= ly_next;
        cin_reg  <= cin_next;
        cout_reg <= cout_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_s_reg <= TIME_W'(3600);
            gl_reg      <= '0;
            gt_reg      <= '0;
            gr_reg      <= '1;
            gb_reg      <= '1;
            facing_reg  <= FACE_0;
            win_reg     <= WIN_W'(30);
            la_reg      <= LA_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RESET_SECONDS:    reset_s_reg <= cfg_data;
                REG_GATE_LEFT:        gl_reg      <= cfg_data[PIX_W-1:0];
                REG_GATE_TOP:         gt_reg      <= cfg_data[PIX_W-1:0];
                REG_GATE_RIGHT:       gr_reg      <= cfg_data[PIX_W-1:0];
                REG_GATE_BOTTOM:      gb_reg      <= cfg_data[PIX_W-1:0];
                REG_GATE_FACING:      facing_reg  <= cfg_data[FACE_W-1:0];
                REG_WINDOW_FRAMES:    win_reg     <= cfg_data[WIN_W-1:0];
                REG_LOOKAHEAD_FRAMES: la_reg      <= cfg_data[LA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> sv/gct_store.sv
module gct_store
    import gct_pkg::*;
#(
    parameter int DEPTH = MAX_RECORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rec_t          wr_data,
    input  logic [AW-1:0] rd_addr,
    output rec_t          rd_data
);

    rec_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/gct_rem.sv
module gct_rem
    import gct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FRAME_W-1:0] dividend,
    input  logic [WIN_W-1:0]   divisor,
    output logic               done,
    output logic [WIN_W-1:0]   remainder
);

    logic [WIN_W-1:0]   rem_reg, rem_next;
    logic [FRAME_W-1:0] dvd_reg, dvd_next;
    logic [WIN_W-1:0]   dsr_reg, dsr_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [WIN_W:0]     trial;

    // Restoring remainder, one dividend bit per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[FRAME_W-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = WIN_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[WIN_W-1:0];
            end
            dvd_next = {dvd_reg[FRAME_W-2:0], 1'b0};
            if (step_reg == STEP_W'(REM_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gct_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

    // Expected-result tracker with its own copy of the record store
    class crossing_scoreboard;
        logic [31:0]      reset_secs;
        logic [PIX_W-1:0] g_left, g_top, g_right, g_bottom;
        facing_t          facing;
        logic [WIN_W-1:0] win_len;
        logic [LA_W-1:0]  look_len;

        int unsigned frm [DEPTH];
        int unsigned ids [DEPTH];
        int unsigned cx2 [DEPTH];
        int unsigned cy2 [DEPTH];
        int unsigned nrec;
        logic [31:0] t0;
        bit          started;

        result_t pending[$];
        int errors, n_rec, n_cnt, n_clear, n_full, n_hits;

        function new();
            reset_secs = 3600;
            g_left = 0;
            g_top = 0;
            g_right = 4095;
            g_bottom = 4095;
            facing = FACE_0;
            win_len = 30;
            look_len = 100;
            nrec = 0;
            t0 = 0;
            started = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_RESET_SECONDS:    reset_secs = d;
                REG_GATE_LEFT:        g_left = d[PIX_W-1:0];
                REG_GATE_TOP:         g_top = d[PIX_W-1:0];
                REG_GATE_RIGHT:       g_right = d[PIX_W-1:0];
                REG_GATE_BOTTOM:      g_bottom = d[PIX_W-1:0];
                REG_GATE_FACING:      facing = facing_t'(d[FACE_W-1:0]);
                REG_WINDOW_FRAMES:    win_len = d[WIN_W-1:0];
                REG_LOOKAHEAD_FRAMES: look_len = d[LA_W-1:0];
                default: ;
            endcase
        endfunction

        function result_t predict(item_t it);
            result_t r;
            longint fmin, fmax, w, d, lo, fend, dx, dy;
            longint wins[$];
            bit seen[longint];
            int unsigned cin, cout, ex, ey, last;
            bit skip;
            r = '0;
            if (it.op == OP_RECORD) begin
                r.frame_used = it.frame_number;
                if (!started) begin
                    t0 = it.now_seconds;
                    started = 1;
                end
                else if (it.now_seconds >= t0 && it.now_seconds - t0 >= reset_secs) begin
                    r.frame_used = 0;
                    r.totals_cleared = 1;
                    nrec = 0;
                    t0 = it.now_seconds;
                end
                if (nrec >= DEPTH) begin
                    r.store_full = 1;
                    return r;
                end
                frm[nrec] = r.frame_used;
                ids[nrec] = it.track_id;
                cx2[nrec] = 2 * int'(it.box_x) + int'(it.box_width);
                cy2[nrec] = 2 * int'(it.box_y) + int'(it.box_height);
                nrec++;
                return r;
            end
            if (nrec == 0)
                return r;
            fmin = frm[0];
            fmax = frm[0];
            for (int i = 1; i < nrec; i++)
            begin
                if (frm[i] < fmin) fmin = frm[i];
                if (frm[i] > fmax) fmax = frm[i];
            end
            w = (win_len == 0) ? 1 : win_len;
            // the window ending at or after each record, and the next on a boundary
            for (int i = 0; i < nrec; i++)
            begin
                d = longint'(frm[i]) - fmin;
                for (int s = 0; s < 2; s++)
                begin
                    longint k;
                    k = (s == 0) ? (d + w - 1) / w : d / w + 1;
                    if (fmin + k * w <= fmax && !seen.exists(k))
                    begin
                        seen[k] = 1;
                        wins.insert(wins.size(), k);
                    end
                end
            end
            cin = 0;
            cout = 0;
            foreach (wins[n])
            begin
                fend = fmin + wins[n] * w;
                lo = fend - w;
                for (int i = 0; i < nrec; i++)
                begin
                    if (longint'(frm[i]) < lo || longint'(frm[i]) > fend) continue;
                    skip = 0;
                    for (int j = 0; j < nrec && !skip; j++)
                    begin
                        if (ids[j] != ids[i]) continue;
                        if (j < i && longint'(frm[j]) >= lo && longint'(frm[j]) <= fend)
                            skip = 1;
                        if (longint'(frm[j]) > fend &&
                            longint'(frm[j]) <= fend + longint'(look_len))
                            skip = 1;
                    end
                    if (skip) continue;
                    last = i;
                    for (int j = i + 1; j < nrec; j++)
                        if (ids[j] == ids[i] && longint'(frm[j]) >= lo &&
                            longint'(frm[j]) <= fend) last = j;
                    ex = cx2[last];
                    ey = cy2[last];
                    dx = longint'(ex) - longint'(cx2[i]);
                    dy = longint'(cy2[i]) - longint'(ey);
                    if (!(int'(g_left) * 32 <= ex && ex <= int'(g_right) * 32 &&
                          int'(g_top) * 32 <= ey && ey <= int'(g_bottom) * 32))
                        continue;
                    case (facing)
                        FACE_0:   if (dx < 0) cin++; else cout++;
                        FACE_90:  if (dy < 0) cin++; else cout++;
                        FACE_180: if (dx < 0) cout++; else cin++;
                        default:  if (dy >= 0) cin++; else cout++;
                    endcase
                end
            end
            r.count_in = (cin > 65535) ? 16'hFFFF : cin[15:0];
            r.count_out = (cout > 65535) ? 16'hFFFF : cout[15:0];
            return r;
        endfunction

        function void note(item_t it);
            pending.insert(pending.size(), predict(it));
            if (it.op == OP_RECORD) n_rec++; else n_cnt++;
        endfunction

        function void check(result_t got);
            result_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (exp.totals_cleared) n_clear++;
            if (exp.store_full) n_full++;
            if (exp.count_in != 0 || exp.count_out != 0) n_hits++;
            if (got.frame_used !== exp.frame_used)
            begin
                $error("frame_used: expected %0d, got %0d", exp.frame_used, got.frame_used);
                errors++;
            end
            if (got.totals_cleared !== exp.totals_cleared)
            begin
                $error("totals_cleared: expected %0d, got %0d",
                       exp.totals_cleared, got.totals_cleared);
                errors++;
            end
            if (got.store_full !== exp.store_full)
            begin
                $error("store_full: expected %0d, got %0d", exp.store_full, got.store_full);
                errors++;
            end
            if (got.count_in !== exp.count_in)
            begin
                $error("count_in: expected %0d, got %0d", exp.count_in, got.count_in);
                errors++;
            end
            if (got.count_out !== exp.count_out)
            begin
                $error("count_out: expected %0d, got %0d", exp.count_out, got.count_out);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    item_t                item;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    crossing_scoreboard sb = new();
    int burst_left;
    int stall_mode;
    int stall_cnt;
    int unsigned base_frame;
    int unsigned base_id;

    gate_crossing_track_counter_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial clk = 0;
    always #5 clk = ~clk;

    // Receiver stalls; the pattern is redrawn at random among three modes
    always @(posedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= $urandom_range(0, 1);
            default: result_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check(result);
    end

    // Run limit
    initial
    begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send(item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        sb.note(it);
        burst_left--;
    endtask

    // Wait for every expected word, then let the block settle
    task automatic drain();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
        cfg_we <= 1'b0;
    endtask

    function automatic item_t rec(int unsigned f, int unsigned id, int unsigned x,
                                  int unsigned y, int unsigned w, int unsigned h,
                                  logic [31:0] now);
        item_t it;
        it.op = OP_RECORD;
        it.frame_number = FRAME_W'(f);
        it.track_id = ID_W'(id);
        it.box_x = BOX_W'(x);
        it.box_y = BOX_W'(y);
        it.box_width = BOX_W'(w);
        it.box_height = BOX_W'(h);
        it.now_seconds = now;
        return it;
    endfunction

    function automatic item_t cnt();
        item_t it;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.op = OP_COUNT;
        return it;
    endfunction

    // Record word on the current episode with a chosen clock behavior
    function automatic item_t rand_rec(int span, int tmode);
        longint now;
        case (tmode)
            0:       now = longint'(sb.t0) + sb.reset_secs;
            1:       now = (sb.t0 > 0) ? sb.t0 - $urandom_range(1, sb.t0 > 500 ? 500 : sb.t0)
                                       : sb.t0;
            default: now = longint'(sb.t0) + $urandom_range(0, sb.reset_secs - 1);
        endcase
        if (now > 64'hFFFF_FFFF) now = sb.t0;
        return rec((base_frame + $urandom_range(0, span)) & 24'hFFFFFF,
                   (base_id + $urandom_range(0, 5)) & 16'hFFFF,
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), now[31:0]);
    endfunction

    initial
    begin
        int span, lft, top, wl, la;
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_ready = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        stall_mode = 0;
        stall_cnt = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extremes, clear, clock backwards, lookahead
        send(cnt());
        send(rec(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
        send(rec(0, 0, 0, 0, 0, 0, 3599));
        send(cnt());
        send(rec(5, 7, 1600, 1600, 16, 16, 3600));
        send(rec(10, 7, 1440, 1600, 16, 16, 10));
        send(rec(12, 9, 3200, 3200, 0, 0, 3601));
        send(rec(20, 9, 3200, 3200, 0, 0, 3602));
        send(rec(14, 11, 800, 900, 32, 32, 3603));
        send(rec(28, 11, 900, 700, 32, 32, 3603));
        send(cnt());
        send(rec(40, 7, 1400, 1600, 16, 16, 3604));
        send(cnt());
        drain();

        // Extreme settings: inverted gate, zero window and lookahead
        set_reg(REG_RESET_SECONDS, 32'hFFFF_FFFF);
        set_reg(REG_GATE_LEFT, 4095);
        set_reg(REG_GATE_TOP, 4095);
        set_reg(REG_GATE_RIGHT, 0);
        set_reg(REG_GATE_BOTTOM, 0);
        set_reg(REG_GATE_FACING, FACE_270);
        set_reg(REG_WINDOW_FRAMES, 0);
        set_reg(REG_LOOKAHEAD_FRAMES, 0);
        set_reg(REG_UNUSED, 32'h1234_5678);
        send(rec(41, 9, 3000, 3300, 0, 0, 32'hFFFF_FFFF));
        send(rec(43, 9, 3100, 3000, 0, 0, 32'hFFFF_FFFF));
        send(cnt());
        drain();
        set_reg(REG_GATE_LEFT, 0);
        set_reg(REG_GATE_TOP, 0);
        set_reg(REG_GATE_RIGHT, 4095);
        set_reg(REG_GATE_BOTTOM, 4095);
        send(cnt());
        drain();
        set_reg(REG_GATE_FACING, FACE_90);
        set_reg(REG_WINDOW_FRAMES, 255);
        set_reg(REG_LOOKAHEAD_FRAMES, 1023);
        send(cnt());
        drain();
        set_reg(REG_GATE_FACING, FACE_180);
        set_reg(REG_RESET_SECONDS, 0);
        send(cnt());
        send(rec(100, 3, 500, 500, 10, 10, 3604));
        send(rec(101, 3, 400, 600, 10, 10, 3604));
        send(cnt());
        drain();

        // Fill the store past its depth, then clear it by time
        set_reg(REG_RESET_SECONDS, 1000000);
        for (int i = 0; i < DEPTH + 3; i++)
            send(rec($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), sb.t0));
        send(rec(1, 1, 0, 0, 0, 0, sb.t0 + 1000000));
        send(cnt());
        drain();

        // Random phases with varied settings
        for (int p = 0; p < 8; p++)
        begin
            lft = $urandom_range(0, 2000);
            top = $urandom_range(0, 2000);
            wl = (p == 0) ? 1 : (p == 1) ? 255 : $urandom_range(1, 60);
            la = (p == 2) ? 1 : (p == 3) ? 1023 : $urandom_range(1, 200);
            set_reg(REG_RESET_SECONDS, $urandom_range(50, 100000));
            set_reg(REG_GATE_LEFT, lft);
            set_reg(REG_GATE_TOP, top);
            set_reg(REG_GATE_RIGHT, $urandom_range(lft, 4095));
            set_reg(REG_GATE_BOTTOM, $urandom_range(top, 4095));
            set_reg(REG_GATE_FACING, p % 4);
            set_reg(REG_WINDOW_FRAMES, wl);
            set_reg(REG_LOOKAHEAD_FRAMES, la);
            span = 3 * wl + ((la > 300) ? 300 : la);
            base_frame = $urandom_range(0, 24'hFFFFFF);
            base_id = $urandom_range(0, 65535);
            for (int n = 0; n < 25; n++)
            begin
                if (sb.nrec >= 18 && $urandom_range(0, 1) == 0)
                    send(cnt());
                else if (sb.nrec >= 18 || $urandom_range(0, 29) == 0)
                begin
                    send(rand_rec(span, 0));
                    base_frame = $urandom_range(0, 24'hFFFFFF);
                    base_id = $urandom_range(0, 65535);
                end
                else if (sb.nrec > 0 && $urandom_range(0, 5) == 0)
                    send(cnt());
                else
                    send(rand_rec(span, ($urandom_range(0, 9) == 0) ? 1 : 2));
            end
            drain();
        end

        $display("Covered %0d record and %0d count words: %0d store clears, %0d full drops,",
                 sb.n_rec, sb.n_cnt, sb.n_clear, sb.n_full);
        $display("%0d counts with crossings, over eight random gate and window settings.",
                 sb.n_hits);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
